// ===== src/granular_contact_force_core_defines.svh =====
// Assertion helpers for the contact force core.
`ifndef GRANULAR_CONTACT_FORCE_CORE_DEFINES_SVH
`define GRANULAR_CONTACT_FORCE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define GCF_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contact force core check failed");

// Next-cycle implication, checked out of reset
`define GCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contact force core check failed");

`endif

// ===== src/gcf_pkg.sv =====
package gcf_pkg;

    // History store
    localparam int PAIR_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(PAIR_SLOTS);

    // Pipeline layout
    localparam int NSTG     = 43;
    localparam int RD_STG   = 36;
    localparam int HIST_STG = 37;
    localparam int LAST_STG = NSTG - 1;

    // Register reset values, Q16.16
    localparam logic [30:0] TIME_STEP_RST   = 31'd66;
    localparam logic [30:0] HERTZ_RST       = 31'd655360000;
    localparam logic [30:0] DAMPING_RST     = 31'd9830400;
    localparam logic [30:0] TANG_STIFF_RST  = 31'd32768000;
    localparam logic [30:0] FRICTION_RST    = 31'd26214;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [2:0] {
        REG_TIME_STEP  = 3'd0,
        REG_HERTZ      = 3'd1,
        REG_DAMPING    = 3'd2,
        REG_TANG_STIFF = 3'd3,
        REG_FRICTION   = 3'd4
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_PASS, ST_MUL0, ST_SUM0, ST_SQD, ST_SINIT, ST_SQS_DIV, ST_SQS, ST_NFIN,
        ST_MUL1, ST_SUM1, ST_MUL2, ST_SUM2, ST_MUL3, ST_HIST, ST_MUL4, ST_MUL5,
        ST_CLAMP, ST_MUL6, ST_OUT
    } stage_kind_t;

    // Input item, pair_slot in the low bits
    typedef struct packed {
        logic [30:0]        mass_second;
        logic [30:0]        mass_first;
        logic [30:0]        radius_second;
        logic [30:0]        radius_first;
        logic signed [31:0] spin_second;
        logic signed [31:0] spin_first;
        logic signed [31:0] delta_vy;
        logic signed [31:0] delta_vx;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_x;
        logic [11:0]        pair_slot;
    } in_t;

    // Result item, padded to whole bytes
    typedef struct packed {
        logic [6:0]         pad;
        logic               in_contact;
        logic signed [31:0] torque_second;
        logic signed [31:0] torque_first;
        logic signed [31:0] force_y;
        logic signed [31:0] force_x;
    } out_t;

    // Everything an item carries down the pipe
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dvx;
        logic signed [31:0] dvy;
        logic signed [31:0] w1;
        logic signed [31:0] w2;
        logic [30:0]        r1;
        logic [30:0]        r2;
        logic [30:0]        m1;
        logic [30:0]        m2;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic signed [63:0] pc;
        logic signed [63:0] pd;
        logic signed [63:0] pe;
        logic signed [63:0] pf;
        logic [31:0]        msum;
        logic [63:0]        sq_src;
        logic [32:0]        sq_rem;
        logic [31:0]        sq_root;
        logic [31:0]        md_rem;
        logic [31:0]        md_src;
        logic [31:0]        md_q;
        logic [31:0]        d;
        logic               d_zero;
        logic               dx_neg;
        logic               dy_neg;
        logic [31:0]        nd_rem_x;
        logic [17:0]        nd_src_x;
        logic [17:0]        nd_q_x;
        logic [31:0]        nd_rem_y;
        logic [17:0]        nd_src_y;
        logic [17:0]        nd_q_y;
        logic               s_pos;
        logic               s_neg;
        logic [30:0]        s_sat;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [30:0]        meff;
        logic [23:0]        sqs;
        logic signed [31:0] w;
        logic signed [31:0] vcn;
        logic signed [31:0] vct;
        logic signed [31:0] s15;
        logic signed [31:0] dsq;
        logic signed [31:0] kterm;
        logic signed [31:0] dm;
        logic signed [31:0] vdt;
        logic signed [31:0] fn;
        logic signed [31:0] x;
        logic [30:0]        fnabs;
        logic signed [31:0] ft;
        logic signed [31:0] ftmax;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
    } item_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) r = 32'sh7fffffff;
        else if (v < SAT_MIN) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Q16.16 product tail: floor shift, then clamp
    function automatic logic signed [31:0] qfin(input logic signed [63:0] p);
        logic signed [63:0] sh;
        sh = p >>> 16;
        return sat32(66'(sh));
    endfunction

    // What each pipe step does
    function automatic stage_kind_t stage_kind(input int unsigned k);
        stage_kind_t r;
        case (k) inside
            0:        r = ST_MUL0;
            1:        r = ST_SUM0;
            [2:17]:   r = ST_SQD;
            18:       r = ST_SINIT;
            [19:27]:  r = ST_SQS_DIV;
            [28:30]:  r = ST_SQS;
            31:       r = ST_NFIN;
            32:       r = ST_MUL1;
            33:       r = ST_SUM1;
            34:       r = ST_MUL2;
            35:       r = ST_SUM2;
            RD_STG:   r = ST_MUL3;
            HIST_STG: r = ST_HIST;
            38:       r = ST_MUL4;
            39:       r = ST_MUL5;
            40:       r = ST_CLAMP;
            41:       r = ST_MUL6;
            LAST_STG: r = ST_OUT;
            default:  r = ST_PASS;
        endcase
        return r;
    endfunction

endpackage

// ===== src/granular_contact_force_core.sv =====
// Each accepted item passes through the stage registers to the output register.
// Throughput: one item per cycle while the skid register is empty; the history
// memory is read one stage ahead of its write, and a same-slot forward keeps
// back-to-back pairs exact. Reset: asynchronous, active low; afterwards a clearing
// pass initializes the pair history memory and s_axis_tready stays low until it ends.
`include "granular_contact_force_core_defines.svh"

module granular_contact_force_core
    import gcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pair_slot[12], delta_x, delta_y, delta_vx, delta_vy, spin_first,
    // spin_second [32 each], radius_first, radius_second, mass_first,
    // mass_second [31 each]
    input  logic [327:0] s_axis_tdata,
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // force_x, force_y, torque_first, torque_second [32 each], in_contact[1],
    // zero pad[7]
    output logic [135:0] m_axis_tdata,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);

    logic [30:0] time_step_reg;
    logic [30:0] hertz_reg;
    logic [30:0] damping_reg;
    logic [30:0] tang_stiff_reg;
    logic [30:0] friction_reg;

    logic              clearing_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;

    logic [NSTG-1:0] vld_reg;
    item_t           pipe_reg  [NSTG];
    item_t           pipe_next [NSTG];
    item_t           load_item;

    logic        pipe_en;
    logic        in_accept;
    logic        hist_we;
    logic [32:0] hist_wdata;
    logic [32:0] hist_rd_reg;
    logic [32:0] hist_mem [PAIR_SLOTS];

    out_t res;
    out_t out_reg;
    out_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;

    in_t in_view;

    // Handshake
    assign pipe_en       = !skid_valid_reg;
    assign s_axis_tready = pipe_en && !clearing_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Unpack the incoming item
    always_comb
    begin
        in_view   = in_t'(s_axis_tdata);
        load_item = '0;
        load_item.slot = in_view.pair_slot[SLOT_W-1:0];
        load_item.dx   = in_view.delta_x;
        load_item.dy   = in_view.delta_y;
        load_item.dvx  = in_view.delta_vx;
        load_item.dvy  = in_view.delta_vy;
        load_item.w1   = in_view.spin_first;
        load_item.w2   = in_view.spin_second;
        load_item.r1   = in_view.radius_first;
        load_item.r2   = in_view.radius_second;
        load_item.m1   = in_view.mass_first;
        load_item.m2   = in_view.mass_second;
    end

    // Per-stage datapath
    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        always_comb
        begin
            item_t             w;
            logic [34:0]       rem2;
            logic [34:0]       trial;
            logic [32:0]       rdm;
            logic [32:0]       rdx;
            logic [32:0]       rdy;
            logic signed [33:0] s_tmp;
            logic [31:0]       ax;
            logic [31:0]       ay;
            w     = pipe_reg[k];
            rem2  = '0;
            trial = '0;
            rdm   = '0;
            rdx   = '0;
            rdy   = '0;
            s_tmp = '0;
            ax    = '0;
            ay    = '0;
            case (stage_kind(k))
                ST_MUL0:
                begin
                    w.pa   = w.dx * w.dx;
                    w.pb   = w.dy * w.dy;
                    w.pc   = $signed({1'b0, w.r1}) * w.w1;
                    w.pd   = $signed({1'b0, w.r2}) * w.w2;
                    w.pe   = $signed({1'b0, w.m1}) * $signed({1'b0, w.m2});
                    w.msum = 32'(w.m1) + 32'(w.m2);
                end
                ST_SUM0:
                begin
                    w.sq_src  = $unsigned(w.pa) + $unsigned(w.pb);
                    w.sq_rem  = '0;
                    w.sq_root = '0;
                    w.w       = sat32(66'(qfin(w.pc)) + 66'(qfin(w.pd)));
                    w.md_rem  = w.pe[63:32];
                    w.md_src  = w.pe[31:0];
                    w.md_q    = '0;
                end
                ST_SINIT:
                begin
                    w.d      = w.sq_root;
                    w.d_zero = (w.sq_root == '0);
                    s_tmp    = $signed(34'(w.r1)) + $signed(34'(w.r2))
                               - $signed(34'(w.sq_root));
                    w.s_pos  = (s_tmp > 34'sd0);
                    w.s_neg  = (s_tmp < 34'sd0);
                    w.s_sat  = (s_tmp > 34'sd2147483647) ? '1 : s_tmp[30:0];
                    // overlap square root input: s * 2^16 in the top 48 bits
                    w.sq_src  = {1'b0, w.s_sat, 32'd0};
                    w.sq_rem  = '0;
                    w.sq_root = '0;
                    // normal division setup, quotient fits 18 bits
                    ax = w.dx[31] ? 32'(-w.dx) : 32'(w.dx);
                    ay = w.dy[31] ? 32'(-w.dy) : 32'(w.dy);
                    w.dx_neg   = w.dx[31];
                    w.dy_neg   = w.dy[31];
                    w.nd_rem_x = 32'(ax[31:2]);
                    w.nd_src_x = {ax[1:0], 16'd0};
                    w.nd_q_x   = '0;
                    w.nd_rem_y = 32'(ay[31:2]);
                    w.nd_src_y = {ay[1:0], 16'd0};
                    w.nd_q_y   = '0;
                end
                ST_NFIN:
                begin
                    w.sqs = w.sq_root[23:0];
                    if (w.d_zero)
                    begin
                        w.nx = 18'sd65536;
                        w.ny = '0;
                    end
                    else
                    begin
                        w.nx = w.dx_neg ? -$signed(w.nd_q_x) : $signed(w.nd_q_x);
                        w.ny = w.dy_neg ? -$signed(w.nd_q_y) : $signed(w.nd_q_y);
                    end
                    w.meff = (w.msum == '0) ? '0 : w.md_q[30:0];
                end
                ST_MUL1:
                begin
                    w.pa = w.dvx * w.nx;
                    w.pb = w.dvy * w.ny;
                    w.pc = w.dvx * w.ny;
                    w.pd = w.dvy * w.nx;
                    w.pe = $signed({1'b0, w.s_sat}) * $signed({8'd0, w.sqs});
                    w.pf = $signed({1'b0, damping_reg}) * $signed({8'd0, w.sqs});
                end
                ST_SUM1:
                begin
                    w.vcn = sat32(66'(qfin(w.pa)) + 66'(qfin(w.pb)));
                    w.vct = sat32(66'(qfin(w.pc)) - 66'(qfin(w.pd)) + 66'(w.w));
                    w.s15 = qfin(w.pe);
                    w.dsq = qfin(w.pf);
                end
                ST_MUL2:
                begin
                    w.pa = $signed({1'b0, hertz_reg}) * w.s15;
                    w.pb = w.dsq * $signed({1'b0, w.meff});
                    w.pc = w.vct * $signed({1'b0, time_step_reg});
                end
                ST_SUM2:
                begin
                    w.kterm = qfin(w.pa);
                    w.dm    = qfin(w.pb);
                    w.vdt   = qfin(w.pc);
                end
                ST_MUL3:
                begin
                    w.pa = w.dm * w.vcn;
                end
                ST_HIST:
                begin
                    w.fn = sat32(66'(w.kterm) - 66'(qfin(w.pa)));
                    w.x  = sat32(66'($signed(hist_rd_reg[31:0])) + 66'(w.vdt));
                end
                ST_MUL4:
                begin
                    w.pa = $signed({1'b0, tang_stiff_reg}) * w.x;
                    if (w.fn == 32'sh80000000) w.fnabs = '1;
                    else if (w.fn < 0) w.fnabs = 31'(-w.fn);
                    else w.fnabs = w.fn[30:0];
                end
                ST_MUL5:
                begin
                    w.pb = $signed({1'b0, friction_reg}) * $signed({1'b0, w.fnabs});
                    w.ft = sat32(-66'(qfin(w.pa)));
                end
                ST_CLAMP:
                begin
                    w.ftmax = qfin(w.pb);
                    if (w.ft > w.ftmax) w.ft = w.ftmax;
                    else if (w.ft < -w.ftmax) w.ft = -w.ftmax;
                end
                ST_MUL6:
                begin
                    w.pa = w.nx * w.fn;
                    w.pb = w.ny * w.ft;
                    w.pc = w.ny * w.fn;
                    w.pd = w.nx * w.ft;
                    w.pe = $signed({1'b0, w.r1}) * w.ft;
                    w.pf = $signed({1'b0, w.r2}) * w.ft;
                end
                ST_OUT:
                begin
                    w.fx = sat32(66'(qfin(w.pa)) + 66'(qfin(w.pb)));
                    w.fy = sat32(66'(qfin(w.pc)) - 66'(qfin(w.pd)));
                    w.t1 = qfin(w.pe);
                    w.t2 = qfin(w.pf);
                    if (!w.s_pos)
                    begin
                        w.fx = '0;
                        w.fy = '0;
                        w.t1 = '0;
                        w.t2 = '0;
                    end
                end
                default:
                begin
                end
            endcase

            // Two square-root digits per stage
            if (stage_kind(k) == ST_SQD || stage_kind(k) == ST_SQS_DIV
                || stage_kind(k) == ST_SQS)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    rem2  = {w.sq_rem, w.sq_src[63:62]};
                    trial = {1'b0, w.sq_root, 2'b01};
                    if (rem2 >= trial)
                    begin
                        rem2      = rem2 - trial;
                        w.sq_root = {w.sq_root[30:0], 1'b1};
                    end
                    else
                    begin
                        w.sq_root = {w.sq_root[30:0], 1'b0};
                    end
                    w.sq_rem = rem2[32:0];
                    w.sq_src = {w.sq_src[61:0], 2'b00};
                end
            end

            // Two effective-mass quotient bits per stage
            if (stage_kind(k) == ST_SQD)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    rdm = {w.md_rem, w.md_src[31]};
                    if (rdm >= {1'b0, w.msum})
                    begin
                        rdm    = rdm - {1'b0, w.msum};
                        w.md_q = {w.md_q[30:0], 1'b1};
                    end
                    else
                    begin
                        w.md_q = {w.md_q[30:0], 1'b0};
                    end
                    w.md_rem = rdm[31:0];
                    w.md_src = {w.md_src[30:0], 1'b0};
                end
            end

            // Two normal-vector quotient bits per stage, x and y side by side
            if (stage_kind(k) == ST_SQS_DIV)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    rdx = {w.nd_rem_x, w.nd_src_x[17]};
                    rdy = {w.nd_rem_y, w.nd_src_y[17]};
                    if (rdx >= {1'b0, w.d})
                    begin
                        rdx      = rdx - {1'b0, w.d};
                        w.nd_q_x = {w.nd_q_x[16:0], 1'b1};
                    end
                    else
                    begin
                        w.nd_q_x = {w.nd_q_x[16:0], 1'b0};
                    end
                    if (rdy >= {1'b0, w.d})
                    begin
                        rdy      = rdy - {1'b0, w.d};
                        w.nd_q_y = {w.nd_q_y[16:0], 1'b1};
                    end
                    else
                    begin
                        w.nd_q_y = {w.nd_q_y[16:0], 1'b0};
                    end
                    w.nd_rem_x = rdx[31:0];
                    w.nd_rem_y = rdy[31:0];
                    w.nd_src_x = {w.nd_src_x[16:0], 1'b0};
                    w.nd_src_y = {w.nd_src_y[16:0], 1'b0};
                end
            end
            pipe_next[k] = w;
        end
    end

    // History update: spring grows in contact, clears when contact breaks
    always_comb
    begin
        hist_we = pipe_en && vld_reg[HIST_STG];
        if (pipe_reg[HIST_STG].s_pos)
            hist_wdata = {1'b1, pipe_next[HIST_STG].x};
        else if (pipe_reg[HIST_STG].s_neg)
            hist_wdata = {1'b0, hist_rd_reg[32] ? 32'd0 : hist_rd_reg[31:0]};
        else
            hist_wdata = {1'b1, hist_rd_reg[31:0]};
    end

    // History memory: {overlap non-negative flag, displacement}
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            hist_mem[clr_cnt_reg] <= {1'b1, 32'd0};
        else if (hist_we)
            hist_mem[pipe_reg[HIST_STG].slot] <= hist_wdata;
        if (pipe_en)
        begin
            // forward a write to the same slot happening this cycle
            if (hist_we && pipe_reg[HIST_STG].slot == pipe_reg[RD_STG].slot)
                hist_rd_reg <= hist_wdata;
            else
                hist_rd_reg <= hist_mem[pipe_reg[RD_STG].slot];
        end
    end

    // Result view of the last stage
    always_comb
    begin
        res               = '0;
        res.force_x       = pipe_next[LAST_STG].fx;
        res.force_y       = pipe_next[LAST_STG].fy;
        res.torque_first  = pipe_next[LAST_STG].t1;
        res.torque_second = pipe_next[LAST_STG].t2;
        res.in_contact    = pipe_next[LAST_STG].s_pos;
    end

    // Control: config, clear pass, valid bits, output and skid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TIME_STEP_RST;
            hertz_reg      <= HERTZ_RST;
            damping_reg    <= DAMPING_RST;
            tang_stiff_reg <= TANG_STIFF_RST;
            friction_reg   <= FRICTION_RST;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIME_STEP:  time_step_reg  <= cfg_wdata;
                    REG_HERTZ:      hertz_reg      <= cfg_wdata;
                    REG_DAMPING:    damping_reg    <= cfg_wdata;
                    REG_TANG_STIFF: tang_stiff_reg <= cfg_wdata;
                    REG_FRICTION:   friction_reg   <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(PAIR_SLOTS - 1))
                    clearing_reg <= 1'b0;
            end
            if (pipe_en)
                vld_reg <= {vld_reg[NSTG-2:0], in_accept};
            if (!skid_valid_reg)
            begin
                if (!out_valid_reg || m_axis_tready)
                    out_valid_reg <= vld_reg[LAST_STG];
                else if (vld_reg[LAST_STG])
                    skid_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pipe_reg[0] <= load_item;
            for (int k = 0; k < NSTG - 1; k++)
                pipe_reg[k+1] <= pipe_next[k];
        end
        if (!skid_valid_reg)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                if (vld_reg[LAST_STG])
                    out_reg <= res;
            end
            else if (vld_reg[LAST_STG])
            begin
                skid_reg <= res;
            end
        end
        else if (m_axis_tready)
        begin
            out_reg <= skid_reg;
        end
    end

    // Checks
    `GCF_ASSERT_HOLDS(a_no_accept_clear, clearing_reg, !s_axis_tready)
    `GCF_ASSERT_HOLDS(a_skid_has_out, skid_valid_reg, out_valid_reg)
    `GCF_ASSERT_HOLDS(a_no_write_clear, clearing_reg, !hist_we && !vld_reg[HIST_STG])
    `GCF_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_axis_tready, skid_valid_reg)
    `GCF_ASSERT_HOLDS(a_idle_zero, out_valid_reg && !out_reg.in_contact,
                      out_reg.force_x == '0 && out_reg.torque_first == '0)

endmodule
